/* design/integrating_velocity_filter_macros.svh */
// Assertion helpers used by the filter's core module.
// Each expects clk and rst in scope.
`ifndef INTEGRATING_VELOCITY_FILTER_MACROS_SVH
`define INTEGRATING_VELOCITY_FILTER_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define IVF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IVF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ivf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ivf_pkg;

  // Commands
  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_DEGREE   = 2'd0;
  localparam logic [1:0] REG_TCONST   = 2'd1;
  localparam logic [1:0] REG_MINDELTA = 2'd2;
  localparam logic [1:0] REG_STOPGAP  = 2'd3;

  localparam logic [63:0] NS_PER_S = 64'd1000000000;
  localparam logic [63:0] ONE_Q16  = 64'd65536;
  localparam logic [63:0] MUL_CAP  = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         pointer_id;
    logic [31:0]        event_mask;
    logic [62:0]        event_time;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic               last_of_event;
  } sample_t;

  typedef struct packed {
    logic [4:0]         out_pointer;
    logic [62:0]        est_time;
    logic [1:0]         est_degree;
    logic signed [23:0] est_pos_x;
    logic signed [23:0] est_pos_y;
    logic signed [39:0] vel_x;
    logic signed [39:0] vel_y;
    logic signed [47:0] half_accel_x;
    logic signed [47:0] half_accel_y;
  } estimate_t;

  typedef struct packed {
    logic [1:0]  filter_degree;
    logic [29:0] time_constant_ns;
    logic [29:0] min_delta_ns;
    logic [31:0] stop_gap_ns;
  } cfg_t;

  // One round(n*b/d) request for the serial unit
  typedef struct packed {
    logic signed [63:0] n;
    logic [63:0]        b;
    logic [63:0]        d;
  } md_req_t;

  // Per-pointer record
  typedef struct packed {
    logic [62:0]        upd;
    logic [1:0]         deg;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [39:0] vel_x;
    logic signed [39:0] vel_y;
    logic signed [47:0] acc_x;
    logic signed [47:0] acc_y;
  } ptr_rec_t;

  function automatic logic signed [39:0] sat40(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_007F_FFFF_FFFF;
    lo = -hi - 64'sd1;
    if (x > hi) return hi[39:0];
    else if (x < lo) return lo[39:0];
    else return x[39:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -hi - 64'sd1;
    if (x > hi) return hi[47:0];
    else if (x < lo) return lo[47:0];
    else return x[47:0];
  endfunction

  // Half, rounded away from zero
  function automatic logic signed [47:0] half48(input logic signed [47:0] a);
    logic [48:0] mag;
    logic [48:0] h;
    mag = a[47] ? (49'd0 - {a[47], a}) : {1'b0, a};
    h = (mag + 49'd1) >> 1;
    return a[47] ? (48'd0 - h[47:0]) : h[47:0];
  endfunction

endpackage

`default_nettype wire

/* design/ivf_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial round(n*b/d): shift-add multiply, one bit a cycle, then
// restoring division, one quotient bit a cycle. Magnitude capped at 2^62.
module ivf_muldiv (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire ivf_pkg::md_req_t req,
  output logic                  done,
  output logic signed [63:0]    q
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [6:0] MUL_LAST = 7'd63;
  localparam logic [6:0] DIV_LAST = 7'd127;

  logic [1:0]  phase;
  logic [6:0]  cnt;
  logic [63:0] hi;
  logic [63:0] lo;
  logic [63:0] bm;
  logic [63:0] dd;
  logic        neg;
  logic [63:0] r;
  logic [62:0] qr;
  logic        big;

  logic [63:0] mag_in;
  logic [64:0] msum;
  logic [64:0] rs;
  logic        ge;
  logic [64:0] rdiff;
  logic [63:0] mag_out;

  // Datapath
  assign mag_in = req.n[63] ? (64'd0 - req.n) : req.n;
  assign msum   = {1'b0, hi} + (lo[0] ? {1'b0, bm} : 65'd0);
  assign rs     = {r, hi[63]};
  assign ge     = rs >= {1'b0, dd};
  assign rdiff  = rs - {1'b0, dd};

  // Saturated, signed result
  assign mag_out = (big || ({1'b0, qr} > ivf_pkg::MUL_CAP)) ? ivf_pkg::MUL_CAP : {1'b0, qr};
  assign q       = neg ? (64'd0 - mag_out) : mag_out;

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= 7'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_MUL;
            cnt   <= 7'd0;
          end
        end
        PH_MUL: begin
          cnt <= cnt + 7'd1;
          if (cnt == MUL_LAST) begin
            phase <= PH_DIV;
            cnt   <= 7'd0;
          end
        end
        PH_DIV: begin
          cnt <= cnt + 7'd1;
          if (cnt == DIV_LAST) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // Shift registers
  always_ff @(posedge clk) begin
    unique case (phase)
      PH_IDLE: begin
        if (start) begin
          hi  <= req.d >> 1;   // rounding term lands in the low word
          lo  <= mag_in;
          bm  <= req.b;
          dd  <= req.d;
          neg <= req.n[63];
          r   <= 64'd0;
          qr  <= 63'd0;
          big <= 1'b0;
        end
      end
      PH_MUL: begin
        hi <= msum[64:1];
        lo <= {msum[0], lo[63:1]};
      end
      PH_DIV: begin
        hi  <= {hi[62:0], lo[63]};
        lo  <= {lo[62:0], 1'b0};
        r   <= ge ? rdiff[63:0] : rs[63:0];
        qr  <= {qr[61:0], ge};
        big <= big | qr[62];
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/ivf_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

// Configuration registers behind the APB-style port.
module ivf_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output ivf_pkg::cfg_t    cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_degree    <= 2'd1;
      cfg.time_constant_ns <= 30'd10000000;
      cfg.min_delta_ns     <= 30'd2000000;
      cfg.stop_gap_ns      <= 32'd40000000;
    end else if (wr) begin
      unique case (paddr[3:2])
        ivf_pkg::REG_DEGREE:   cfg.filter_degree    <= pwdata[1:0];
        ivf_pkg::REG_TCONST:   cfg.time_constant_ns <= pwdata[29:0];
        ivf_pkg::REG_MINDELTA: cfg.min_delta_ns     <= pwdata[29:0];
        ivf_pkg::REG_STOPGAP:  cfg.stop_gap_ns      <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      ivf_pkg::REG_DEGREE:   prdata = {30'd0, cfg.filter_degree};
      ivf_pkg::REG_TCONST:   prdata = {2'd0, cfg.time_constant_ns};
      ivf_pkg::REG_MINDELTA: prdata = {2'd0, cfg.min_delta_ns};
      ivf_pkg::REG_STOPGAP:  prdata = cfg.stop_gap_ns;
      default:               prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* design/ivf_core.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "integrating_velocity_filter_macros.svh"

// Command decode, pointer store and the update sequencer that feeds the
// serial multiply-divide unit one operation at a time.
module ivf_core #(
  parameter int POINTER_SLOTS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ivf_pkg::cfg_t       cfg,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire ivf_pkg::sample_t    sample,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output ivf_pkg::estimate_t       res
);

  localparam int IDX_W = (POINTER_SLOTS > 1) ? $clog2(POINTER_SLOTS) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_ISSUE  = 3'd3;
  localparam logic [2:0] ST_WAIT   = 3'd4;
  localparam logic [2:0] ST_AXEND  = 3'd5;
  localparam logic [2:0] ST_STORE  = 3'd6;
  localparam logic [2:0] ST_EMIT   = 3'd7;

  localparam logic [2:0] OP_ALPHA = 3'd0;
  localparam logic [2:0] OP_V     = 3'd1;
  localparam logic [2:0] OP_VFILT = 3'd2;
  localparam logic [2:0] OP_A     = 3'd3;
  localparam logic [2:0] OP_AFILT = 3'd4;
  localparam logic [2:0] OP_INT1  = 3'd5;
  localparam logic [2:0] OP_INT2  = 3'd6;

  // Control
  logic [2:0]               state;
  logic [2:0]               op;
  logic                     axis;
  logic [POINTER_SLOTS-1:0] tracked;
  logic [62:0]              let_time;
  logic                     mid;

  // Latched word and working set
  logic [1:0]         cmd;
  logic [4:0]         id;
  logic [31:0]        mask;
  logic [62:0]        t;
  logic signed [23:0] npos [2];
  logic               last;
  logic               is_tracked;
  logic [62:0]        upd;
  logic [1:0]         deg;
  logic signed [23:0] pos [2];
  logic signed [39:0] vel [2];
  logic signed [47:0] acc [2];
  logic [63:0]        dt;
  logic [16:0]        alpha;
  logic signed [39:0] v;
  logic signed [47:0] a;
  logic signed [63:0] tmp;

  // Pointer store
  ivf_pkg::ptr_rec_t mem [POINTER_SLOTS];
  ivf_pkg::ptr_rec_t rd;
  ivf_pkg::ptr_rec_t wr_rec;
  logic              mem_we;

  logic [IDX_W-1:0]         idx;
  logic [POINTER_SLOTS-1:0] mask_s;
  logic                     gap_hit;
  logic [POINTER_SLOTS-1:0] tr_gap;
  logic                     id_ok;
  logic                     second;
  logic                     late;

  logic              md_start;
  ivf_pkg::md_req_t  md_req;
  logic              md_done;
  logic signed [63:0] md_q;

  assign idx     = id[IDX_W-1:0];
  assign mask_s  = mask[POINTER_SLOTS-1:0];
  assign id_ok   = {1'b0, id} < 6'(POINTER_SLOTS);
  assign second  = cfg.filter_degree[1];
  assign gap_hit = !mid && (|(tracked & mask_s)) &&
                   ({1'b0, t} >= ({1'b0, let_time} + {32'd0, cfg.stop_gap_ns}));
  assign tr_gap  = gap_hit ? '0 : tracked;
  assign late    = {1'b0, t} > ({1'b0, rd.upd} + {34'd0, cfg.min_delta_ns});

  assign sample_stall = state != ST_IDLE;
  assign md_start     = state == ST_ISSUE;
  assign mem_we       = state == ST_STORE;
  assign res_valid    = state == ST_EMIT;

  ivf_muldiv u_md (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .req   (md_req),
    .done  (md_done),
    .q     (md_q)
  );

  // Store port: registered read, write of the working record
  always_comb begin
    wr_rec.upd   = upd;
    wr_rec.deg   = deg;
    wr_rec.pos_x = pos[0];
    wr_rec.pos_y = pos[1];
    wr_rec.vel_x = vel[0];
    wr_rec.vel_y = vel[1];
    wr_rec.acc_x = acc[0];
    wr_rec.acc_y = acc[1];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[idx] <= wr_rec;
    rd <= mem[idx];
  end

  // Operand select for the current operation
  always_comb begin
    md_req.n = 64'sd0;
    md_req.b = 64'd0;
    md_req.d = 64'd1;
    unique case (op)
      OP_ALPHA: begin
        md_req.n = {34'd0, cfg.time_constant_ns};
        md_req.b = ivf_pkg::ONE_Q16;
        md_req.d = {34'd0, cfg.time_constant_ns} + dt;
      end
      OP_V: begin
        md_req.n = 64'(npos[axis]) - 64'(pos[axis]);
        md_req.b = ivf_pkg::NS_PER_S;
        md_req.d = dt;
      end
      OP_VFILT: begin
        md_req.n = 64'(v) - 64'(vel[axis]);
        md_req.b = {47'd0, alpha};
        md_req.d = ivf_pkg::ONE_Q16;
      end
      OP_A: begin
        md_req.n = 64'(v) - 64'(vel[axis]);
        md_req.b = ivf_pkg::NS_PER_S;
        md_req.d = dt;
      end
      OP_AFILT: begin
        md_req.n = 64'(a) - 64'(acc[axis]);
        md_req.b = {47'd0, alpha};
        md_req.d = ivf_pkg::ONE_Q16;
      end
      OP_INT1: begin
        md_req.n = 64'(acc[axis]);
        md_req.b = dt;
        md_req.d = ivf_pkg::NS_PER_S;
      end
      OP_INT2: begin
        md_req.n = tmp;
        md_req.b = {47'd0, alpha};
        md_req.d = ivf_pkg::ONE_Q16;
      end
      default: ;
    endcase
  end

  // Sequencer and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op       <= OP_ALPHA;
      axis     <= 1'b0;
      tracked  <= '0;
      let_time <= 63'd0;
      mid      <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (sample_valid) state <= ST_DECODE;
        end
        ST_DECODE: begin
          state <= ST_IDLE;
          unique case (cmd)
            ivf_pkg::CMD_SAMPLE: begin
              tracked  <= last ? mask_s : tr_gap;
              let_time <= t;
              mid      <= !last;
              if (id_ok) state <= ST_LOAD;
            end
            ivf_pkg::CMD_RELEASE: tracked <= tracked & ~mask_s;
            ivf_pkg::CMD_CLEAR:   tracked <= '0;
            default: ;
          endcase
        end
        ST_LOAD: begin
          if (!is_tracked) begin
            state <= ST_STORE;
          end else if (late) begin
            op    <= OP_ALPHA;
            axis  <= 1'b0;
            state <= ST_ISSUE;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (md_done) begin
            state <= ST_ISSUE;
            unique case (op)
              OP_ALPHA: op <= OP_V;
              OP_V: begin
                if (deg == 2'd0) state <= ST_AXEND;
                else if (!second) op <= OP_VFILT;
                else op <= OP_A;
              end
              OP_VFILT: state <= ST_AXEND;
              OP_A:     op <= (deg == 2'd1) ? OP_INT1 : OP_AFILT;
              OP_AFILT: op <= OP_INT1;
              OP_INT1:  op <= OP_INT2;
              OP_INT2:  state <= ST_AXEND;
              default:  state <= ST_AXEND;
            endcase
          end
        end
        ST_AXEND: begin
          if (!axis) begin
            axis  <= 1'b1;
            op    <= OP_V;
            state <= ST_ISSUE;
          end else begin
            state <= ST_STORE;
          end
        end
        ST_STORE: state <= ST_EMIT;
        ST_EMIT: begin
          if (!res_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd     <= sample.cmd;
          id      <= sample.pointer_id;
          mask    <= sample.event_mask;
          t       <= sample.event_time;
          npos[0] <= sample.pos_x;
          npos[1] <= sample.pos_y;
          last    <= sample.last_of_event;
        end
      end
      ST_DECODE: is_tracked <= id_ok && tr_gap[idx];
      ST_LOAD: begin
        if (!is_tracked) begin
          upd    <= t;
          deg    <= 2'd0;
          pos[0] <= npos[0];
          pos[1] <= npos[1];
          vel[0] <= 40'sd0;
          vel[1] <= 40'sd0;
          acc[0] <= 48'sd0;
          acc[1] <= 48'sd0;
        end else begin
          upd    <= rd.upd;
          deg    <= rd.deg;
          pos[0] <= rd.pos_x;
          pos[1] <= rd.pos_y;
          vel[0] <= rd.vel_x;
          vel[1] <= rd.vel_y;
          acc[0] <= rd.acc_x;
          acc[1] <= rd.acc_y;
          dt     <= {1'b0, t} - {1'b0, rd.upd};
        end
      end
      ST_WAIT: begin
        if (md_done) begin
          unique case (op)
            OP_ALPHA: alpha <= 17'h10000 - md_q[16:0];
            OP_V: begin
              v <= ivf_pkg::sat40(md_q);
              if (deg == 2'd0) vel[axis] <= ivf_pkg::sat40(md_q);
            end
            OP_VFILT: vel[axis] <= ivf_pkg::sat40(64'(vel[axis]) + md_q);
            OP_A: begin
              a <= ivf_pkg::sat48(md_q);
              if (deg == 2'd1) acc[axis] <= ivf_pkg::sat48(md_q);
            end
            OP_AFILT: acc[axis] <= ivf_pkg::sat48(64'(acc[axis]) + md_q);
            OP_INT1:  tmp <= md_q;
            OP_INT2:  vel[axis] <= ivf_pkg::sat40(64'(vel[axis]) + md_q);
            default: ;
          endcase
        end
      end
      ST_AXEND: begin
        pos[axis] <= npos[axis];
        if (axis) begin
          upd <= t;
          if (deg == 2'd0) deg <= 2'd1;
          else if (second && deg == 2'd1) deg <= 2'd2;
        end
      end
      default: ;
    endcase
  end

  // Result word
  always_comb begin
    res.out_pointer  = id;
    res.est_time     = upd;
    res.est_degree   = deg;
    res.est_pos_x    = pos[0];
    res.est_pos_y    = pos[1];
    res.vel_x        = vel[0];
    res.vel_y        = vel[1];
    res.half_accel_x = ivf_pkg::half48(acc[0]);
    res.half_accel_y = ivf_pkg::half48(acc[1]);
  end

  `IVF_ASSERT_NOW(a_done_in_wait, md_done, state == ST_WAIT, "multiply-divide result outside wait")
  `IVF_ASSERT_NEXT(a_accept_decodes, sample_valid && !sample_stall, state == ST_DECODE, "word not decoded")
  `IVF_ASSERT_NOW(a_emit_degree, state == ST_EMIT, deg != 2'd3, "pointer degree out of range")

endmodule

`default_nettype wire

/* design/integrating_velocity_filter.sv */
// Channel    Direction  Handshake                       Word
// sample     in         sample_valid / sample_stall     ivf_pkg::sample_t
// estimate   out        estimate_valid / estimate_stall ivf_pkg::estimate_t
// config     in/out     psel / penable / pready         32-bit registers at 4*i
//
// Each multiply-divide is issued, runs 64 multiply and 128 divide steps, then
// signals done; all updates share that one serial unit, one word at a time.
// Release, clear and out-of-range words end after decode; a close sample is
// loaded and emitted, a new pointer stored too; updates chain multiply-divides.
// Synchronous reset; the pointer store needs no clearing pass.
// A stalled estimate sits in the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none

module integrating_velocity_filter #(
  parameter int POINTER_SLOTS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sample_valid,
  output logic                    sample_stall,
  input  wire ivf_pkg::sample_t   sample,
  output logic                    estimate_valid,
  input  wire logic               estimate_stall,
  output ivf_pkg::estimate_t      estimate,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  ivf_pkg::cfg_t      cfg;
  logic               res_valid;
  logic               res_stall;
  ivf_pkg::estimate_t res;

  ivf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ivf_core #(
    .POINTER_SLOTS (POINTER_SLOTS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res          (res)
  );

  // Output register
  assign res_stall = estimate_valid && estimate_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      estimate_valid <= 1'b0;
    end else if (!res_stall) begin
      estimate_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_stall && res_valid) estimate <= res;
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int RANDOM_WORDS = 255;

  logic clk;
  logic rst;
  logic sample_valid;
  logic sample_stall;
  ivf_pkg::sample_t sample;
  logic estimate_valid;
  logic estimate_stall;
  ivf_pkg::estimate_t estimate;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  integrating_velocity_filter dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .estimate_valid(estimate_valid), .estimate_stall(estimate_stall),
    .estimate(estimate),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Expected estimates, oldest first
  ivf_pkg::estimate_t pending_est[$];
  int errors;
  int idle_cycles;
  bit quiet;
  bit hold_req;

  // Tracker copy: configuration
  logic [1:0]  trk_degree;
  logic [63:0] trk_tconst;
  logic [63:0] trk_min_delta;
  logic [63:0] trk_stop_gap;
  // Tracker copy: event state and pointer store
  logic [63:0] trk_mask;
  logic [63:0] trk_last_t;
  bit          trk_mid;
  logic [63:0] p_upd[32];
  logic [1:0]  p_deg[32];
  longint      p_px[32], p_py[32], p_vx[32], p_vy[32], p_ax[32], p_ay[32];

  // Stimulus bookkeeping
  logic [31:0] written_ids;
  longint      last_x[32], last_y[32];
  logic [62:0] now_ns;

  // round(a*b/d) on the exact product, capped
  function automatic logic [63:0] round_muldiv(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] d);
    logic [128:0] p;
    p = {65'd0, a} * {65'd0, b};
    p = p + {65'd0, d >> 1};
    p = p / {65'd0, d};
    if (p > {65'd0, ivf_pkg::MUL_CAP}) return ivf_pkg::MUL_CAP;
    return p[63:0];
  endfunction

  function automatic longint signed_muldiv(longint n, logic [63:0] b, logic [63:0] d);
    logic [63:0] mag;
    logic [63:0] q;
    mag = n < 0 ? 64'd0 - 64'(n) : 64'(n);
    q = round_muldiv(mag, b, d);
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp(longint x, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic longint half_away(longint a);
    logic [63:0] mag;
    logic [63:0] h;
    mag = a < 0 ? 64'd0 - 64'(a) : 64'(a);
    h = (mag + 64'd1) >> 1;
    return a < 0 ? -longint'(h) : longint'(h);
  endfunction

  // One axis of the alpha-filter update
  task automatic advance_axis(inout longint pos, inout longint vel, inout longint acc,
                              input longint np, input logic [1:0] deg,
                              input logic [63:0] dt, input logic [63:0] alpha,
                              input bit second);
    longint v;
    longint a;
    v = clamp(signed_muldiv(np - pos, ivf_pkg::NS_PER_S, dt), 40);
    if (deg == 2'd0) begin
      vel = v;
    end else if (!second) begin
      vel = clamp(vel + signed_muldiv(v - vel, alpha, ivf_pkg::ONE_Q16), 40);
    end else begin
      a = clamp(signed_muldiv(v - vel, ivf_pkg::NS_PER_S, dt), 48);
      if (deg == 2'd1) acc = a;
      else acc = clamp(acc + signed_muldiv(a - acc, alpha, ivf_pkg::ONE_Q16), 48);
      vel = clamp(vel + signed_muldiv(signed_muldiv(acc, dt, ivf_pkg::NS_PER_S), alpha,
                                      ivf_pkg::ONE_Q16), 40);
    end
    pos = np;
  endtask

  task automatic track_word(input ivf_pkg::sample_t w, output bit produced,
                            output ivf_pkg::estimate_t e);
    logic [63:0] t;
    logic [63:0] dt;
    logic [63:0] alpha;
    logic [63:0] mask;
    int id;
    bit second;
    produced = 0;
    e = '0;
    t = {1'b0, w.event_time};
    mask = {32'd0, w.event_mask};
    id = w.pointer_id;
    if (w.cmd == ivf_pkg::CMD_RELEASE) begin
      trk_mask = trk_mask & ~mask;
    end else if (w.cmd == ivf_pkg::CMD_CLEAR) begin
      trk_mask = '0;
    end else if (w.cmd == ivf_pkg::CMD_SAMPLE) begin
      if (!trk_mid && (trk_mask & mask) != 0 && t >= trk_last_t + trk_stop_gap)
        trk_mask = '0;
      trk_last_t = t;
      trk_mid = 1;
      if (!trk_mask[id]) begin
        p_upd[id] = t;
        p_deg[id] = 2'd0;
        p_px[id] = w.pos_x;
        p_py[id] = w.pos_y;
        p_vx[id] = 0; p_vy[id] = 0; p_ax[id] = 0; p_ay[id] = 0;
      end else if (t > p_upd[id] + trk_min_delta) begin
        dt = t - p_upd[id];
        alpha = ivf_pkg::ONE_Q16 - round_muldiv(trk_tconst, ivf_pkg::ONE_Q16,
                                                trk_tconst + dt);
        second = trk_degree >= 2'd2;
        advance_axis(p_px[id], p_vx[id], p_ax[id], w.pos_x, p_deg[id], dt, alpha, second);
        advance_axis(p_py[id], p_vy[id], p_ay[id], w.pos_y, p_deg[id], dt, alpha, second);
        if (p_deg[id] == 2'd0) p_deg[id] = 2'd1;
        else if (second && p_deg[id] == 2'd1) p_deg[id] = 2'd2;
        p_upd[id] = t;
      end
      e.out_pointer = w.pointer_id;
      e.est_time = p_upd[id][62:0];
      e.est_degree = p_deg[id];
      e.est_pos_x = p_px[id][23:0];
      e.est_pos_y = p_py[id][23:0];
      e.vel_x = p_vx[id][39:0];
      e.vel_y = p_vy[id][39:0];
      e.half_accel_x = 48'(half_away(p_ax[id]));
      e.half_accel_y = 48'(half_away(p_ay[id]));
      produced = 1;
      if (w.last_of_event) begin
        trk_mask = mask;
        trk_mid = 0;
      end
    end
  endtask

  function automatic ivf_pkg::sample_t make_word(logic [1:0] cmd, int id, logic [31:0] mask,
                                                 logic [62:0] t, longint x, longint y,
                                                 bit last);
    ivf_pkg::sample_t w;
    w.cmd = cmd;
    w.pointer_id = id[4:0];
    w.event_mask = mask;
    w.event_time = t;
    w.pos_x = x[23:0];
    w.pos_y = y[23:0];
    w.last_of_event = last;
    return w;
  endfunction

  // Estimate of a pointer that has just started
  function automatic ivf_pkg::estimate_t fresh_est(int id, logic [62:0] t, longint x,
                                                   longint y);
    ivf_pkg::estimate_t e;
    e = '0;
    e.out_pointer = id[4:0];
    e.est_time = t;
    e.est_pos_x = x[23:0];
    e.est_pos_y = y[23:0];
    return e;
  endfunction

  // Offer one word; when it is taken, queue what it should produce
  task automatic send_word(input ivf_pkg::sample_t w, input bit typed,
                           input ivf_pkg::estimate_t typed_est);
    int gap;
    bit produced;
    ivf_pkg::estimate_t e;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample <= w;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    track_word(w, produced, e);
    if (w.cmd == ivf_pkg::CMD_SAMPLE) written_ids[w.pointer_id] = 1'b1;
    if (produced) pending_est.push_back(typed ? typed_est : e);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ivf_pkg::REG_DEGREE:   trk_degree = value[1:0];
      ivf_pkg::REG_TCONST:   trk_tconst = {34'd0, value[29:0]};
      ivf_pkg::REG_MINDELTA: trk_min_delta = {34'd0, value[29:0]};
      ivf_pkg::REG_STOPGAP:  trk_stop_gap = {32'd0, value};
      default: ;
    endcase
  endtask

  // Block is idle once nothing is owed and the slack has passed
  task automatic drain();
    sample_valid <= 1'b0;
    while (pending_est.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic longint move(longint p, bit wild);
    longint n;
    if (wild) return longint'($signed($urandom() << 8) >>> 8);
    n = p + longint'($urandom_range(0, 8000)) - 4000;
    return clamp(n, 24);
  endfunction

  // Random events: mostly well-formed touches, some commands and broken events
  task automatic random_words(input int count);
    int sent;
    int k;
    int id;
    int r;
    logic [31:0] ev_ids;
    logic [31:0] mask;
    int ids[$];
    bit wild;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_word(make_word(ivf_pkg::CMD_RELEASE, $urandom_range(0, 31), $urandom(),
                            now_ns, 0, 0, $urandom_range(0, 1)), 0, '0);
        sent++;
      end else if (r < 6) begin
        send_word(make_word(ivf_pkg::CMD_CLEAR, 0, $urandom(), now_ns, 0, 0, 0), 0, '0);
        sent++;
      end else if (r < 8) begin
        send_word(make_word(2'd3, $urandom_range(0, 31), $urandom(), now_ns,
                            0, 0, 1), 0, '0);
        sent++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) now_ns += 63'($urandom_range(0, 3000000));
        else if (r < 85) now_ns += 63'($urandom_range(3000000, 30000000));
        else if (r < 95) now_ns += 63'($urandom_range(40000000, 200000000));
        else now_ns += 63'($urandom_range(0, 1000)) * 63'd10000000;
        k = $urandom_range(1, 4);
        ev_ids = '0;
        ids.delete();
        while (ids.size() < k) begin
          id = $urandom_range(0, 31);
          if (!ev_ids[id]) begin
            ev_ids[id] = 1'b1;
            ids.push_back(id);
          end
        end
        // other bits only for pointers that have been sampled before
        mask = ev_ids | (written_ids & $urandom() & $urandom());
        foreach (ids[i]) begin
          wild = $urandom_range(0, 15) == 0;
          last_x[ids[i]] = move(last_x[ids[i]], wild);
          last_y[ids[i]] = move(last_y[ids[i]], wild);
          // one event in twenty never closes
          send_word(make_word(ivf_pkg::CMD_SAMPLE, ids[i], mask, now_ns, last_x[ids[i]],
                              last_y[ids[i]],
                              i == ids.size() - 1 && $urandom_range(0, 19) != 0),
                    0, '0);
          sent++;
        end
      end
    end
  endtask

  typedef struct {
    ivf_pkg::sample_t   w;
    bit                 typed;
    ivf_pkg::estimate_t e;
  } step_row_t;

  // Compare accepted estimates against the oldest expectation
  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ivf_pkg::estimate_t e;
    if (!rst && estimate_valid && !estimate_stall) begin
      if (pending_est.size() == 0) begin
        $error("estimate with none expected: pointer %0d", estimate.out_pointer);
        errors++;
      end else begin
        e = pending_est.pop_front();
        check_field("out_pointer", 64'(e.out_pointer), 64'(estimate.out_pointer));
        check_field("est_time", 64'(e.est_time), 64'(estimate.est_time));
        check_field("est_degree", 64'(e.est_degree), 64'(estimate.est_degree));
        check_field("est_pos_x", 64'(e.est_pos_x), 64'(estimate.est_pos_x));
        check_field("est_pos_y", 64'(e.est_pos_y), 64'(estimate.est_pos_y));
        check_field("vel_x", 64'(e.vel_x), 64'(estimate.vel_x));
        check_field("vel_y", 64'(e.vel_y), 64'(estimate.vel_y));
        check_field("half_accel_x", 64'(e.half_accel_x), 64'(estimate.half_accel_x));
        check_field("half_accel_y", 64'(e.half_accel_y), 64'(estimate.half_accel_y));
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (estimate_valid && !estimate_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Estimate side: random stalls, one long hold-off on request
  initial begin
    int n;
    estimate_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        estimate_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      n = quiet ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        estimate_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      estimate_stall <= 1'b0;
      do @(posedge clk); while (!estimate_valid);
      @(negedge clk);
    end
  end

  initial begin
    step_row_t rows[$];
    longint mx;
    longint mn;
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    idle_cycles = 0;
    quiet = 0;
    hold_req = 0;
    trk_degree = 2'd1;
    trk_tconst = 64'd10000000;
    trk_min_delta = 64'd2000000;
    trk_stop_gap = 64'd40000000;
    trk_mask = '0;
    trk_last_t = '0;
    trk_mid = 0;
    written_ids = '0;
    now_ns = '0;
    for (int i = 0; i < 32; i++) begin
      last_x[i] = 0;
      last_y[i] = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, close samples, release, clear, unknown command, stop gap
    mx = 8388607;
    mn = -8388608;
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 0, 32'h1, 0, mx, mx, 0), 1,
                     fresh_est(0, 0, mx, mx)});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 31, 32'h8000_0001, 0, mn, mn, 1), 1,
                     fresh_est(31, 0, mn, mn)});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 0, 32'h8000_0001, 1000000, 5, 5, 0), 1,
                     fresh_est(0, 0, mx, mx)});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 31, 32'h8000_0001, 1000000, 5, 5, 1),
                     1, fresh_est(31, 0, mn, mn)});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 0, 32'h8000_0001, 10000000, mn, mn, 0),
                     0, '0});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 31, 32'h8000_0001, 10000000, mx, mx, 1),
                     0, '0});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 0, 32'h8000_0001, 13000000, mx, mn, 0),
                     0, '0});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 31, 32'h8000_0001, 13000000, mn, mx, 1),
                     0, '0});
    rows.push_back('{make_word(ivf_pkg::CMD_RELEASE, 0, 32'h1, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 0, 32'h1, 20000000, 100, -100, 1), 1,
                     fresh_est(0, 20000000, 100, -100)});
    rows.push_back('{make_word(ivf_pkg::CMD_CLEAR, 0, 32'hFFFF_FFFF, 0, 0, 0, 0), 0, '0});
    rows.push_back('{make_word(2'd3, 7, 32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF,
                               -1, -1, 1), 0, '0});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 5, 32'h20, 100000000, 256, 512, 1), 1,
                     fresh_est(5, 100000000, 256, 512)});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 5, 32'h20, 200000000, 1000, 2000, 1), 1,
                     fresh_est(5, 200000000, 1000, 2000)});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 5, 32'h20, 210000000, 3000, 1000, 1),
                     0, '0});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 5, 32'h20, 220000000, 9000, -4000, 1),
                     0, '0});
    rows.push_back('{make_word(ivf_pkg::CMD_SAMPLE, 5, 32'h20, 235000000, 9100, -4100, 1),
                     0, '0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].e);
    now_ns = 63'd300000000;
    random_words(RANDOM_WORDS);
    drain();

    // Degree 2, fastest filter, no minimum spacing, immediate stop gap
    write_reg(ivf_pkg::REG_DEGREE, 32'd2);
    write_reg(ivf_pkg::REG_TCONST, 32'd1);
    write_reg(ivf_pkg::REG_MINDELTA, 32'd0);
    write_reg(ivf_pkg::REG_STOPGAP, 32'd0);
    hold_req = 1;
    random_words(RANDOM_WORDS);
    drain();

    // Degree 3 acts as 2; slowest filter, longest stop gap; no idling here
    write_reg(ivf_pkg::REG_DEGREE, 32'd3);
    write_reg(ivf_pkg::REG_TCONST, 32'd1000000000);
    write_reg(ivf_pkg::REG_STOPGAP, 32'd4000000000);
    write_reg(ivf_pkg::REG_MINDELTA, 32'd1000);
    quiet = 1;
    random_words(RANDOM_WORDS);
    drain();
    quiet = 0;

    // Degree 0 acts as 1; widest minimum spacing
    write_reg(ivf_pkg::REG_DEGREE, 32'd0);
    write_reg(ivf_pkg::REG_TCONST, 32'd5000000);
    write_reg(ivf_pkg::REG_MINDELTA, 32'd1000000000);
    write_reg(ivf_pkg::REG_STOPGAP, 32'd40000000);
    random_words(RANDOM_WORDS / 2);
    drain();

    // Degree 2 with late timestamps so the top time bits toggle
    write_reg(ivf_pkg::REG_DEGREE, 32'd2);
    write_reg(ivf_pkg::REG_TCONST, 32'd10000000);
    write_reg(ivf_pkg::REG_MINDELTA, 32'd2000000);
    send_word(make_word(ivf_pkg::CMD_CLEAR, 0, 32'd0, now_ns, 0, 0, 0), 0, '0);
    now_ns = 63'h7FFF_FF00_0000_0000;
    random_words(RANDOM_WORDS);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* integrating_velocity_filter.f */
+incdir+design
design/ivf_pkg.sv
design/ivf_muldiv.sv
design/ivf_cfg.sv
design/ivf_core.sv
design/integrating_velocity_filter.sv
tb/sv/testbench.sv
